>>> src/cse_pkg.sv
// ----------------------------------------------------------------------------
// cse_pkg
// Shared widths, beat types and queue status for the cosine similarity engine.
// ----------------------------------------------------------------------------
package cse_pkg;

  localparam int ELEM_W  = 16;            // input element width, Q1.15
  localparam int ACC_W   = 48;            // accumulator width
  localparam int HALF_W  = ACC_W / 2;     // partial product operand width
  localparam int PROD_W  = 2 * ACC_W;     // full product width
  localparam int QUO_W   = 30;            // saturating quotient width
  localparam int ROOT_W  = QUO_W / 2;     // square root width
  localparam int CNT_W   = $clog2(QUO_W); // back-end step counter
  localparam int SIM_W   = 16;            // result width, Q2.14

  localparam logic [SIM_W-1:0] ONE_Q14 = SIM_W'(16384);

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic signed [ELEM_W-1:0] elem_a;
    logic signed [ELEM_W-1:0] elem_b;
    logic                     last_element;
  } in_item_t;

  typedef struct packed {
    logic signed [SIM_W-1:0] similarity;
    logic                    zero_norm;
  } out_item_t;

  // one finished vector pair: raw sums handed to the back end
  typedef struct packed {
    logic [ACC_W-1:0] dot_sum;
    logic [ACC_W-1:0] energy_a;
    logic [ACC_W-1:0] energy_b;
  } job_t;

  typedef struct packed {
    logic [Q_CW-1:0] count;
    logic            empty;
  } q_stat_t;

endpackage

>>> src/cse_front.sv
// ----------------------------------------------------------------------------
// cse_front
// Takes element pairs, registers the three products and accumulates them.
// On the last pair the sums go to the job queue and the accumulators clear.
// ----------------------------------------------------------------------------
module cse_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  cse_pkg::in_item_t item,
  input  cse_pkg::q_stat_t  q_stat,
  output logic              push,
  output cse_pkg::job_t     push_job
);
  import cse_pkg::*;

  logic signed [2*ELEM_W-1:0] prod_ab;
  logic signed [2*ELEM_W-1:0] prod_aa;
  logic signed [2*ELEM_W-1:0] prod_bb;
  logic                       p_valid;
  logic                       p_last;
  logic [ACC_W-1:0]           dot_sum;
  logic [ACC_W-1:0]           energy_a;
  logic [ACC_W-1:0]           energy_b;
  logic [ACC_W-1:0]           dot_sum_next;
  logic [ACC_W-1:0]           energy_a_next;
  logic [ACC_W-1:0]           energy_b_next;
  logic [Q_CW:0]              occ;
  logic                       accept;

  // a last beat in the product stage pushes this cycle but is not yet in count, so count it as taken
  assign occ        = {1'b0, q_stat.count} + {{Q_CW{1'b0}}, p_valid & p_last};
  assign item_stall = occ >= (Q_CW + 1)'(Q_DEPTH);
  assign accept     = item_valid & ~item_stall;

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_ab <= item.elem_a * item.elem_b;
      prod_aa <= item.elem_a * item.elem_a;
      prod_bb <= item.elem_b * item.elem_b;
      p_last  <= item.last_element;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= accept;
    end
  end

  assign dot_sum_next  = dot_sum  + {{(ACC_W-2*ELEM_W){prod_ab[2*ELEM_W-1]}}, prod_ab};
  assign energy_a_next = energy_a + {{(ACC_W-2*ELEM_W){prod_aa[2*ELEM_W-1]}}, prod_aa};
  assign energy_b_next = energy_b + {{(ACC_W-2*ELEM_W){prod_bb[2*ELEM_W-1]}}, prod_bb};

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_sum  <= '0;
      energy_a <= '0;
      energy_b <= '0;
    end else if (p_valid) begin
      if (p_last) begin
        dot_sum  <= '0;
        energy_a <= '0;
        energy_b <= '0;
      end else begin
        dot_sum  <= dot_sum_next;
        energy_a <= energy_a_next;
        energy_b <= energy_b_next;
      end
    end
  end

  assign push              = p_valid & p_last;
  assign push_job.dot_sum  = dot_sum_next;
  assign push_job.energy_a = energy_a_next;
  assign push_job.energy_b = energy_b_next;

  a_last_pushes: assert property (@(posedge clk) disable iff (rst)
    (accept && item.last_element) |=> push)
    else $error("last beat did not push a job");

endmodule

>>> src/cse_queue.sv
// ----------------------------------------------------------------------------
// cse_queue
// Short job queue between the accumulating front end and the divider back end.
// ----------------------------------------------------------------------------
module cse_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cse_pkg::job_t    push_job,
  input  logic             pop,
  output cse_pkg::job_t    pop_job,
  output cse_pkg::q_stat_t stat
);
  import cse_pkg::*;

  job_t            slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_CW-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr + Q_AW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + Q_CW'(1);
        2'b01:   count <= count - Q_CW'(1);
        default: count <= count;
      endcase
    end
  end

  assign pop_job     = slots[rd_ptr];
  assign stat.count  = count;
  assign stat.empty  = (count == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != Q_CW'(Q_DEPTH)))
    else $error("job queue overflow");

endmodule

>>> src/cse_back.sv
// ----------------------------------------------------------------------------
// cse_back
// Per job: |dot|^2 and energy_a*energy_b on one 24x24 multiplier (8 steps),
// restoring divide to a 30-bit saturating quotient, then a bit-serial integer
// square root. k = min(16384, (isqrt(Q)+1)/2), sign of dot applied.
// ----------------------------------------------------------------------------
module cse_back (
  input  logic               clk,
  input  logic               rst,
  input  cse_pkg::q_stat_t   q_stat,
  input  cse_pkg::job_t      job,
  output logic               pop,
  output logic               result_valid,
  input  logic               result_stall,
  output cse_pkg::out_item_t result
);
  import cse_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_CHK  = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_SQRT = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  cnt;
  logic              neg;
  logic              zero;
  logic              sat;
  logic [ACC_W-1:0]  mag;
  logic [ACC_W-1:0]  ea;
  logic [ACC_W-1:0]  eb;
  logic [PROD_W-1:0] acc;
  logic [PROD_W-1:0] prd;
  logic [PROD_W:0]   rem;
  logic [QUO_W-1:0]  quo;
  logic [QUO_W-1:0]  op;
  logic [QUO_W-1:0]  res;
  logic [QUO_W-1:0]  one;

  // multiplier datapath
  logic              phase;
  logic [1:0]        pj;
  logic [ACC_W-1:0]  mx;
  logic [ACC_W-1:0]  my;
  logic [HALF_W-1:0] xp;
  logic [HALF_W-1:0] yp;
  logic [ACC_W-1:0]  pp;
  logic [PROD_W-1:0] pp_sh;
  logic [PROD_W-1:0] acc_sum;

  // divider / root datapath
  logic [PROD_W:0]   r2;
  logic              ge;
  logic [QUO_W-1:0]  quo_next;
  logic [QUO_W-1:0]  trial;
  logic              take;

  logic [ACC_W-1:0]  mag_in;
  logic [ROOT_W:0]   root_up;
  logic [SIM_W-1:0]  k;
  logic              load;

  assign phase = cnt[2];
  assign pj    = cnt[1:0];
  assign mx    = phase ? ea : mag;
  assign my    = phase ? eb : mag;
  assign xp    = pj[1] ? mx[ACC_W-1:HALF_W] : mx[HALF_W-1:0];
  assign yp    = pj[0] ? my[ACC_W-1:HALF_W] : my[HALF_W-1:0];
  assign pp    = xp * yp;

  always_comb begin
    unique case ({1'b0, pj[1]} + {1'b0, pj[0]})
      2'd0:    pp_sh = {{ACC_W{1'b0}}, pp};
      2'd1:    pp_sh = {{HALF_W{1'b0}}, pp, {HALF_W{1'b0}}};
      default: pp_sh = {pp, {ACC_W{1'b0}}};
    endcase
  end

  assign acc_sum  = acc + pp_sh;

  assign r2       = {rem[PROD_W-1:0], 1'b0};
  assign ge       = r2 >= {1'b0, prd};
  assign quo_next = {quo[QUO_W-2:0], ge};

  assign trial    = res + one;
  assign take     = op >= trial;

  assign mag_in   = job.dot_sum[ACC_W-1] ? (~job.dot_sum + ACC_W'(1)) : job.dot_sum;

  // quotient below 2^30 keeps the root below 2^15
  assign root_up  = {1'b0, res[ROOT_W-1:0]} + (ROOT_W + 1)'(1);
  assign k        = sat ? ONE_Q14 : SIM_W'(root_up >> 1);

  assign pop  = (state == ST_IDLE) && !q_stat.empty;
  assign load = (state == ST_FIN) && (!result_valid || !result_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          state_next = (job.energy_a == '0 || job.energy_b == '0) ? ST_FIN : ST_MUL;
        end
      end
      ST_MUL: begin
        if (cnt == CNT_W'(7)) state_next = ST_CHK;
      end
      ST_CHK: begin
        state_next = (rem[PROD_W-1:0] >= prd) ? ST_FIN : ST_DIV;
      end
      ST_DIV: begin
        if (cnt == CNT_W'(QUO_W - 1)) state_next = ST_SQRT;
      end
      ST_SQRT: begin
        if (cnt == CNT_W'(ROOT_W - 1)) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        cnt  <= '0;
        acc  <= '0;
        sat  <= 1'b0;
        zero <= (job.energy_a == '0) || (job.energy_b == '0);
        neg  <= job.dot_sum[ACC_W-1];
        mag  <= mag_in;
        ea   <= job.energy_a;
        eb   <= job.energy_b;
      end
      ST_MUL: begin
        cnt <= cnt + CNT_W'(1);
        if (pj == 2'd3) begin
          acc <= '0;
          if (phase) begin
            prd <= acc_sum;
          end else begin
            rem <= {1'b0, acc_sum};
          end
        end else begin
          acc <= acc_sum;
        end
      end
      ST_CHK: begin
        cnt <= '0;
        quo <= '0;
        sat <= rem[PROD_W-1:0] >= prd;
      end
      ST_DIV: begin
        rem <= ge ? (r2 - {1'b0, prd}) : r2;
        quo <= quo_next;
        if (cnt == CNT_W'(QUO_W - 1)) begin
          cnt <= '0;
          op  <= quo_next;
          res <= '0;
          one <= QUO_W'(1) << (QUO_W - 2);
        end else begin
          cnt <= cnt + CNT_W'(1);
        end
      end
      ST_SQRT: begin
        cnt <= cnt + CNT_W'(1);
        one <= one >> 2;
        if (take) begin
          op  <= op - trial;
          res <= (res >> 1) + one;
        end else begin
          res <= res >> 1;
        end
      end
      ST_FIN: begin
        cnt <= '0;
      end
      default: begin
        cnt <= '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.zero_norm  <= zero;
      result.similarity <= zero ? '0 : (neg ? (~k + SIM_W'(1)) : k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    (load && zero) |=> (result.similarity == '0) && result.zero_norm)
    else $error("zero-energy job gave nonzero similarity");

  a_range: assert property (@(posedge clk) disable iff (rst)
    load |=> ($signed(result.similarity) <= $signed(ONE_Q14))
             && ($signed(result.similarity) >= -$signed(ONE_Q14)))
    else $error("similarity outside +-1.0");

endmodule

>>> src/cosine_similarity_engine.sv
// ----------------------------------------------------------------------------
// cosine_similarity_engine
// Streaming cosine similarity of two Q1.15 vectors, result in Q2.14.
// ----------------------------------------------------------------------------
//  channel  | valid        | stall        | payload           | dir
//  ---------+--------------+--------------+-------------------+----
//  items    | item_valid   | item_stall   | item   (in_item_t)  | in
//  results  | result_valid | result_stall | result (out_item_t) | out
//
//  One element pair beat per cycle while item_stall is low; the registered
//  products accumulate in the next cycle. The back end takes one job at a time:
//  pop, 8 multiply steps on one 24x24 multiplier, range check, 30 divide steps,
//  15 root steps, finish (shorter on zero energy or saturation); 4-entry queue.
//  item_stall rises when the queue is full, counting a job about to be pushed;
//  result_stall parks the back end at its finish step, the front keeps going.
//  rst is synchronous; it clears the accumulators, queue and all control.
// ----------------------------------------------------------------------------
module cosine_similarity_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  cse_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_stall,
  output cse_pkg::out_item_t result
);
  import cse_pkg::*;

  logic    push;
  logic    pop;
  job_t    push_job;
  job_t    pop_job;
  q_stat_t q_stat;

  cse_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_stat     (q_stat),
    .push       (push),
    .push_job   (push_job)
  );

  cse_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .stat     (q_stat)
  );

  cse_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_stat       (q_stat),
    .job          (pop_job),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
